// ===== hw/rtl/lnc_pkg.sv =====
// Package for the LFSR noise channel generator.
// Holds the field widths, the divisor table and the period function.
// Has no dependencies.
package lnc_pkg;

    localparam int unsigned CTRL_W    = 8;
    localparam int unsigned LFSR_W    = 15;
    localparam int unsigned CNT_W     = 23;
    localparam int unsigned CYC_W     = 4;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned PADDR_W   = 3;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h7FFF;
    localparam int unsigned       TAP7_BIT  = 6;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic REG_NOISE_CONTROL = 1'b0;

    typedef logic [CTRL_W-1:0] ctrl_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [LFSR_W-1:0] lfsr_t;

    function automatic logic [6:0] divisor_of(input logic [2:0] code);
        logic [6:0] d;
        case (code)
            3'd0:    d = 7'd8;
            3'd1:    d = 7'd16;
            3'd2:    d = 7'd32;
            3'd3:    d = 7'd48;
            3'd4:    d = 7'd64;
            3'd5:    d = 7'd80;
            3'd6:    d = 7'd96;
            default: d = 7'd112;
        endcase
        return d;
    endfunction

    function automatic count_t period_of(input ctrl_t ctrl);
        logic [CNT_W-1:0] base;
        logic [4:0]       sh;
        base = {{(CNT_W-7){1'b0}}, divisor_of(ctrl[2:0])};
        sh   = {1'b0, ctrl[7:4]} + 5'd1;
        return base << sh;
    endfunction

    localparam count_t PERIOD_RESET = 23'd16;

endpackage

// ===== hw/rtl/lnc_in_if.sv =====
// Input channel of the LFSR noise channel generator: valid/ready and item.
// Depends on lnc_pkg.
interface lnc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [lnc_pkg::CYC_W-1:0]  elapsed_cycles;

    modport source (output valid, output operation, output elapsed_cycles, input ready);
    modport sink   (input valid, input operation, input elapsed_cycles, output ready);
endinterface

// ===== hw/rtl/lnc_out_if.sv =====
// Result channel of the LFSR noise channel generator: valid/ready and item.
// Depends on lnc_pkg.
interface lnc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        noise_bit;
    logic [lnc_pkg::LFSR_W-1:0]  lfsr_value;
    logic                        shifted;

    modport source (output valid, output noise_bit, output lfsr_value, output shifted,
                    input ready);
    modport sink   (input valid, input noise_bit, input lfsr_value, input shifted,
                    output ready);
endinterface

// ===== hw/rtl/lfsr_noise_channel_generator.sv =====
// Top level of the LFSR noise channel generator: period timer, 15-bit LFSR,
// result register and APB control register. Depends on lnc_pkg, lnc_in_if, lnc_out_if.
//
// One item is taken per clock cycle and its result is loaded into the output
// register as the item is taken; the block keeps taking items while the output
// register drains, stalling only when that register is full and not taken.
// The timer and the LFSR are updated in the cycle the item is taken, so each
// item sees the state left by the one before it. The period is recomputed
// from noise_control at the register write.
module lfsr_noise_channel_generator
(
    input  logic                          clk,
    input  logic                          rst_n,
    lnc_in_if.sink                        in_ch,
    lnc_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lnc_pkg::PADDR_W-1:0]   paddr,
    input  logic [lnc_pkg::PDATA_W-1:0]   pwdata,
    output logic [lnc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    lnc_pkg::ctrl_t  ctrl_reg;
    lnc_pkg::count_t period_reg;
    lnc_pkg::count_t count_reg,  count_next;
    lnc_pkg::lfsr_t  lfsr_reg,   lfsr_next;
    logic            bit_reg,    bit_next;
    logic            did_shift;
    logic            out_valid_reg;
    logic            out_bit_reg;
    lnc_pkg::lfsr_t  out_lfsr_reg;
    logic            out_shift_reg;

    logic            cfg_write;
    logic            accept;
    lnc_pkg::count_t cyc_ext;
    lnc_pkg::count_t over;
    lnc_pkg::lfsr_t  shifted_lfsr;
    logic            fb;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == lnc_pkg::REG_NOISE_CONTROL);
    assign prdata    = (paddr[2] == lnc_pkg::REG_NOISE_CONTROL)
                       ? {{(lnc_pkg::PDATA_W-lnc_pkg::CTRL_W){1'b0}}, ctrl_reg}
                       : '0;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign cyc_ext = {{(lnc_pkg::CNT_W-lnc_pkg::CYC_W){1'b0}}, in_ch.elapsed_cycles};
    assign over    = cyc_ext - count_reg;
    assign fb      = lfsr_reg[0] ^ lfsr_reg[1];

    always_comb
    begin
        shifted_lfsr = {fb, lfsr_reg[lnc_pkg::LFSR_W-1:1]};
        if (ctrl_reg[3])
        begin
            shifted_lfsr[lnc_pkg::TAP7_BIT] = fb;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        lfsr_next  = lfsr_reg;
        bit_next   = bit_reg;
        did_shift  = 1'b0;
        case (in_ch.operation)
            lnc_pkg::OP_RESTART:
            begin
                count_next = period_reg;
                lfsr_next  = lnc_pkg::LFSR_SEED;
                bit_next   = 1'b0;
            end
            default:
            begin
                if (in_ch.elapsed_cycles != '0)
                begin
                    if (cyc_ext < count_reg)
                    begin
                        count_next = count_reg - cyc_ext;
                    end
                    else
                    begin
                        count_next = (period_reg > over) ? (period_reg - over)
                                                         : lnc_pkg::count_t'(1);
                        lfsr_next  = shifted_lfsr;
                        bit_next   = ~shifted_lfsr[0];
                        did_shift  = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            period_reg <= lnc_pkg::PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            ctrl_reg   <= pwdata[lnc_pkg::CTRL_W-1:0];
            period_reg <= lnc_pkg::period_of(pwdata[lnc_pkg::CTRL_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= lnc_pkg::PERIOD_RESET;
            lfsr_reg      <= lnc_pkg::LFSR_SEED;
            bit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                lfsr_reg  <= lfsr_next;
                bit_reg   <= bit_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_bit_reg   <= bit_next;
            out_lfsr_reg  <= lfsr_next;
            out_shift_reg <= did_shift;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.noise_bit  = out_bit_reg;
    assign out_ch.lfsr_value = out_lfsr_reg;
    assign out_ch.shifted    = out_shift_reg;

endmodule

// ===== verif/tb_lfsr_noise_channel_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LFSR noise channel generator: directed and random
// ticks and restarts under several noise_control settings, checked against a local predictor.
// Depends on lnc_pkg, lnc_in_if, lnc_out_if and lfsr_noise_channel_generator.
module tb_lfsr_noise_channel_generator;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned REPORT_CAP  = 50;
    localparam int unsigned DIVISORS [8] = '{8, 16, 32, 48, 64, 80, 96, 112};
    localparam int unsigned CYC_W       = lnc_pkg::CYC_W;
    localparam int unsigned PADDR_W     = lnc_pkg::PADDR_W;
    localparam int unsigned PDATA_W     = lnc_pkg::PDATA_W;

    typedef struct {
        logic             op;
        logic [CYC_W-1:0] cyc;
    } channel_op_t;

    typedef struct {
        logic           noise_bit;
        lnc_pkg::lfsr_t lfsr_value;
        logic           shifted;
    } noise_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    lnc_in_if  in_ch ();
    lnc_out_if out_ch ();

    lfsr_noise_channel_generator DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    channel_op_t     channel_ops [$];
    noise_result_t   noise_results_due [$];
    channel_op_t     next_op;

    lnc_pkg::ctrl_t  model_ctrl;
    lnc_pkg::lfsr_t  model_lfsr;
    lnc_pkg::count_t model_count;
    logic            model_out;

    int unsigned   send_idle_pct;
    int unsigned   recv_idle_pct;
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    bit            op_taken;

    always #6 clk = ~clk;

    function automatic lnc_pkg::count_t noise_period(input lnc_pkg::ctrl_t c);
        return lnc_pkg::count_t'(DIVISORS[c[2:0]] << (int'(c[7:4]) + 1));
    endfunction

    function automatic noise_result_t advance_noise_channel(input logic op,
                                                            input logic [CYC_W-1:0] cyc);
        noise_result_t   r;
        lnc_pkg::count_t per;
        lnc_pkg::count_t over;
        logic            fb;
        r.shifted = 1'b0;
        if (op == lnc_pkg::OP_RESTART)
        begin
            model_count = noise_period(model_ctrl);
            model_lfsr  = lnc_pkg::LFSR_SEED;
            model_out   = 1'b0;
        end
        else if (cyc != '0)
        begin
            if (lnc_pkg::count_t'(cyc) < model_count)
            begin
                model_count = model_count - lnc_pkg::count_t'(cyc);
            end
            else
            begin
                over        = lnc_pkg::count_t'(cyc) - model_count;
                per         = noise_period(model_ctrl);
                model_count = (per > over) ? per - over : lnc_pkg::count_t'(1);
                fb          = model_lfsr[0] ^ model_lfsr[1];
                model_lfsr  = {fb, model_lfsr[lnc_pkg::LFSR_W-1:1]};
                if (model_ctrl[3])
                    model_lfsr[lnc_pkg::TAP7_BIT] = fb;
                model_out = ~model_lfsr[0];
                r.shifted = 1'b1;
            end
        end
        r.noise_bit  = model_out;
        r.lfsr_value = model_lfsr;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_CAP)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic push_op(input logic op, input int unsigned cyc);
        channel_op_t item;
        item.op  = op;
        item.cyc = CYC_W'(cyc);
        channel_ops.push_back(item);
    endtask

    task automatic wait_channel_idle();
        do @(posedge clk);
        while (channel_ops.size() != 0 || in_ch.valid || noise_results_due.size() != 0);
        @(negedge clk);
    endtask

    task automatic write_control(input lnc_pkg::ctrl_t value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(4 * int'(lnc_pkg::REG_NOISE_CONTROL));
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        model_ctrl = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(value))
            report_mismatch($sformatf("noise_control read %0h, wrote %0h", prdata, value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // accept items and results
    always @(posedge clk)
    begin
        noise_result_t want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            noise_results_due.push_back(advance_noise_channel(in_ch.operation,
                                                              in_ch.elapsed_cycles));
            op_taken = 1'b1;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (noise_results_due.size() == 0)
            begin
                report_mismatch("result with none expected");
            end
            else
            begin
                want = noise_results_due.pop_front();
                if (out_ch.noise_bit !== want.noise_bit)
                    report_mismatch($sformatf("noise_bit got %0b want %0b",
                                              out_ch.noise_bit, want.noise_bit));
                if (out_ch.lfsr_value !== want.lfsr_value)
                    report_mismatch($sformatf("lfsr_value got %h want %h",
                                              out_ch.lfsr_value, want.lfsr_value));
                if (out_ch.shifted !== want.shifted)
                    report_mismatch($sformatf("shifted got %0b want %0b",
                                              out_ch.shifted, want.shifted));
            end
        end
    end

    // drive items and result backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || op_taken)
            begin
                if (channel_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_op = channel_ops.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.operation      <= next_op.op;
                    in_ch.elapsed_cycles <= next_op.cyc;
                end
                else
                begin
                    in_ch.valid          <= 1'b0;
                    in_ch.operation      <= 1'($urandom_range(1));
                    in_ch.elapsed_cycles <= CYC_W'($urandom_range(15));
                end
            end
            op_taken = 1'b0;
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        lnc_pkg::ctrl_t c;
        int unsigned    n_items;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.operation      = lnc_pkg::OP_TICK;
        in_ch.elapsed_cycles = '0;
        out_ch.ready         = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        op_taken             = 1'b0;
        mismatch_count       = 0;
        cycle_count          = 0;
        send_idle_pct        = 10;
        recv_idle_pct        = 54;
        model_ctrl           = '0;
        model_lfsr           = lnc_pkg::LFSR_SEED;
        model_count          = noise_period('0);
        model_out            = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset period of 16: exact expiry, overshoot and restart
        push_op(lnc_pkg::OP_TICK, 0);
        push_op(lnc_pkg::OP_TICK, 15);
        push_op(lnc_pkg::OP_TICK, 1);
        push_op(lnc_pkg::OP_TICK, 15);
        push_op(lnc_pkg::OP_TICK, 15);
        push_op(lnc_pkg::OP_TICK, 15);
        push_op(lnc_pkg::OP_RESTART, 15);
        push_op(lnc_pkg::OP_TICK, 8);
        push_op(lnc_pkg::OP_TICK, 8);
        push_op(lnc_pkg::OP_RESTART, 0);
        push_op(lnc_pkg::OP_TICK, 15);
        push_op(lnc_pkg::OP_TICK, 15);
        wait_channel_idle();

        // seven-bit mode
        write_control(8'h08);
        repeat (8) push_op(lnc_pkg::OP_TICK, 15);
        push_op(lnc_pkg::OP_RESTART, 0);
        push_op(lnc_pkg::OP_TICK, 15);
        wait_channel_idle();

        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < 4)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 54;
            end
            else if (phase < 8)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 0)
                c = 8'hFF;
            else if (phase == 1)
                c = 8'h00;
            else
            begin
                c = lnc_pkg::ctrl_t'($urandom_range(255));
                if ($urandom_range(3) != 0)
                    c[7:4] = 4'($urandom_range(1));
            end
            write_control(c);
            n_items = (phase == 0) ? 30 : 50;
            repeat (n_items)
            begin
                if ($urandom_range(15) == 0)
                    push_op(lnc_pkg::OP_RESTART, $urandom_range(15));
                else
                    push_op(lnc_pkg::OP_TICK, $urandom_range(15));
            end
            wait_channel_idle();
        end

        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lnc_pkg.sv
hw/rtl/lnc_in_if.sv
hw/rtl/lnc_out_if.sv
hw/rtl/lfsr_noise_channel_generator.sv
verif/tb_lfsr_noise_channel_generator.sv
